FILE: sv/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// checked property, disabled while reset is asserted
`define APQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked property, also evaluated during reset
`define APQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define APQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define APQ_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

FILE: sv/apq_pkg.sv
package apq_pkg;

    // default depth of the point store
    localparam int MaxPointsDefault = 64;

    // width of one stored point field
    localparam int PointW = 32;

    // command codes carried in tuser
    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // one stored point, x in the lowest bits
    typedef struct packed {
        logic [PointW-1:0] age;
        logic [PointW-1:0] life;
        logic [PointW-1:0] z;
        logic [PointW-1:0] y;
        logic [PointW-1:0] x;
    } t_point;

endpackage

FILE: sv/aging_point_queue.sv
// aging_point_queue: ordered store of trail points with aging and expiry
//
// input stream (s_axis): one word per command, tuser selects add or tick.
//   add  appends a point (x, y, z, lifetime) with age zero; when the store
//        is full the oldest point is dropped
//   tick adds time_step to every age (saturating) and removes, in order,
//        every point whose age exceeds its lifetime; no effect below two points
// output stream (m_axis): one word per command, the number of points held.
//
// the points live in one synchronous ram used as a ring: a head pointer marks
// the oldest point, so a full add only overwrites the head slot.
// an add writes its point and goes to S_POST; a tick walks the live points
// through the single ram read port, one point per cycle, then goes to S_POST
// (straight from S_IDLE when fewer than two points are held). the next word is
// taken in the cycle after the result is loaded.
// the result sits in an output register; a new command is accepted while it
// waits, but the next result is held back until the receiver takes the first.
// reset (synchronous, active low) empties the store at once; ram contents are
// not cleared, the count alone tells which entries are live.
`include "assert_macros.svh"

module aging_point_queue #(
    parameter int MAX_POINTS = apq_pkg::MaxPointsDefault,
    localparam int IW = $clog2(MAX_POINTS),
    localparam int CW = $clog2(MAX_POINTS + 1),
    localparam int OW = ((CW + 7) / 8) * 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // pos_x [31:0], pos_y [63:32], pos_z [95:64], life_span [127:96],
    // time_step [159:128]
    input  logic [159:0]  s_axis_tdata,
    // command [0]
    input  logic          s_axis_tuser,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // points_held [CW-1:0], zero above
    output logic [OW-1:0] m_axis_tdata
);

    localparam int PW = apq_pkg::PointW;

    typedef enum logic [1:0] {
        S_IDLE,
        S_TICK,
        S_POST
    } t_state;

    // map a ring offset to a ram address
    function automatic logic [IW-1:0] slot_addr(input logic [IW-1:0] head,
                                                input logic [IW-1:0] off);
        logic [IW:0] sum;
        sum = {1'b0, head} + {1'b0, off};
        if (sum >= (IW + 1)'(MAX_POINTS)) begin
            sum = sum - (IW + 1)'(MAX_POINTS);
        end
        return sum[IW-1:0];
    endfunction

    // point store
    apq_pkg::t_point r_mem [MAX_POINTS];
    apq_pkg::t_point r_rdata;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_cnt, n_cnt;          // live points
    logic [IW-1:0]   r_head, n_head;        // slot of the oldest point
    logic [CW-1:0]   r_rd_issue, n_rd_issue; // next ring offset to read
    logic            r_rd_vld, n_rd_vld;    // r_rdata holds a point this cycle
    logic [CW-1:0]   r_wr, n_wr;            // next ring offset to keep into
    logic [PW-1:0]   r_step, n_step;
    logic            r_out_valid, n_out_valid;
    logic [CW-1:0]   r_out_cnt, n_out_cnt;

    logic            mem_we;
    logic [IW-1:0]   mem_waddr;
    logic [IW-1:0]   mem_raddr;
    apq_pkg::t_point mem_wdata;

    logic            in_acc;
    logic            out_free;
    logic [PW:0]     age_sum;
    logic [PW-1:0]   age_new;
    logic            keep;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OW'(r_out_cnt);

    // aging of the point coming out of the ram, saturating
    assign age_sum = {1'b0, r_rdata.age} + {1'b0, r_step};
    assign age_new = age_sum[PW] ? {PW{1'b1}} : age_sum[PW-1:0];
    assign keep    = (age_new <= r_rdata.life);

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_head      = r_head;
        n_rd_issue  = r_rd_issue;
        n_rd_vld    = 1'b0;
        n_wr        = r_wr;
        n_step      = r_step;
        n_out_valid = r_out_valid;
        n_out_cnt   = r_out_cnt;
        mem_we      = 1'b0;
        mem_waddr   = r_head;
        mem_raddr   = r_head;
        mem_wdata   = r_rdata;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (s_axis_tuser == apq_pkg::CMD_ADD) begin
                        mem_we         = 1'b1;
                        mem_wdata.x    = s_axis_tdata[31:0];
                        mem_wdata.y    = s_axis_tdata[63:32];
                        mem_wdata.z    = s_axis_tdata[95:64];
                        mem_wdata.life = s_axis_tdata[127:96];
                        mem_wdata.age  = '0;
                        if (r_cnt < CW'(MAX_POINTS)) begin
                            mem_waddr = slot_addr(r_head, r_cnt[IW-1:0]);
                            n_cnt     = r_cnt + CW'(1);
                        end else begin
                            // full: the oldest slot takes the new point
                            mem_waddr = r_head;
                            n_head    = slot_addr(r_head, IW'(1));
                        end
                        n_state = S_POST;
                    end else if (r_cnt < CW'(2)) begin
                        n_state = S_POST;
                    end else begin
                        n_step     = s_axis_tdata[159:128];
                        mem_raddr  = r_head;
                        n_rd_issue = CW'(1);
                        n_rd_vld   = 1'b1;
                        n_wr       = '0;
                        n_state    = S_TICK;
                    end
                end
            end
            S_TICK: begin
                // compaction: writes trail reads, so no entry is read after
                // it has been overwritten
                if (r_rd_vld) begin
                    if (keep) begin
                        mem_we        = 1'b1;
                        mem_waddr     = slot_addr(r_head, r_wr[IW-1:0]);
                        mem_wdata     = r_rdata;
                        mem_wdata.age = age_new;
                        n_wr          = r_wr + CW'(1);
                    end
                    if (r_rd_issue < r_cnt) begin
                        mem_raddr  = slot_addr(r_head, r_rd_issue[IW-1:0]);
                        n_rd_issue = r_rd_issue + CW'(1);
                        n_rd_vld   = 1'b1;
                    end
                end else begin
                    n_cnt   = r_wr;
                    n_state = S_POST;
                end
            end
            S_POST: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_cnt   = r_cnt;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_head      <= '0;
            r_rd_issue  <= '0;
            r_rd_vld    <= 1'b0;
            r_wr        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_head      <= n_head;
            r_rd_issue  <= n_rd_issue;
            r_rd_vld    <= n_rd_vld;
            r_wr        <= n_wr;
            r_out_valid <= n_out_valid;
        end
        r_step    <= n_step;
        r_out_cnt <= n_out_cnt;
    end

    // ram: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    `APQ_ASSERT(a_cnt_bound, i_clk, i_rst_n, r_cnt <= CW'(MAX_POINTS), "count beyond depth")
    `APQ_ASSERT(a_wr_trails_rd, i_clk, i_rst_n, (r_state == S_TICK) |-> (r_wr <= r_rd_issue), "compaction write passed read")
    `APQ_ASSERT(a_add_grows, i_clk, i_rst_n, (in_acc && s_axis_tuser == apq_pkg::CMD_ADD && r_cnt < CW'(MAX_POINTS)) |=> (r_cnt == $past(r_cnt) + CW'(1)), "add did not grow count")
    `APQ_ASSERT(a_short_tick, i_clk, i_rst_n, (in_acc && s_axis_tuser == apq_pkg::CMD_TICK && r_cnt < CW'(2)) |=> (r_state == S_POST && $stable(r_cnt)), "tick below two points changed state")

endmodule

FILE: test/aging_point_queue_test.sv
module aging_point_queue_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int Depth = apq_pkg::MaxPointsDefault;
    localparam int CountW = $clog2(Depth + 1);
    localparam int OutW = ((CountW + 7) / 8) * 8;
    // cycles without any word moving on either side before the run is abandoned
    localparam int WatchdogLimit = 2000;
    // a full tick walks every point, so let a few of those pass at the end
    localparam int SettleCycles = 3 * (Depth + 2);
    localparam int MaxReported = 10;
    localparam logic [apq_pkg::PointW-1:0] AgeMax = '1;

    // one command word, pos_x in the lowest bits
    typedef struct packed {
        logic [apq_pkg::PointW-1:0] time_step;
        logic [apq_pkg::PointW-1:0] life_span;
        logic [apq_pkg::PointW-1:0] pos_z;
        logic [apq_pkg::PointW-1:0] pos_y;
        logic [apq_pkg::PointW-1:0] pos_x;
    } t_command_word;

    typedef enum int {RX_OPEN, RX_RANDOM, RX_THROTTLED} t_rx_mode;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            s_axis_tvalid = 1'b0;
    logic            s_axis_tready;
    // pos_x, pos_y, pos_z, life_span, time_step from the lowest bit up
    logic [159:0]    s_axis_tdata = '0;
    // command
    logic            s_axis_tuser = apq_pkg::CMD_ADD;
    logic            m_axis_tvalid;
    logic            m_axis_tready = 1'b0;
    // points_held, zero above
    logic [OutW-1:0] m_axis_tdata;

    aging_point_queue #(
        .MAX_POINTS(Depth)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // point trail predictor: its own copy of the store, oldest point first
    // ------------------------------------------------------------------
    apq_pkg::t_point trail [Depth];
    int unsigned     trail_count = 0;

    // point counts still owed by the block, oldest first
    logic [CountW-1:0] held_expected [$];

    int error_count = 0;

    function automatic logic [CountW-1:0] advance_trail(logic cmd, t_command_word w);
        int unsigned kept;
        logic [apq_pkg::PointW-1:0] aged;
        kept = 0;
        if (cmd == apq_pkg::CMD_ADD) begin
            // full store: drop the oldest point, the rest move down one slot
            if (trail_count == Depth) begin
                for (int k = 0; k < Depth - 1; k++) trail[k] = trail[k + 1];
                trail_count--;
            end
            trail[trail_count] = '{age: '0, life: w.life_span, z: w.pos_z,
                                   y: w.pos_y, x: w.pos_x};
            trail_count++;
        end else if (trail_count >= 2) begin
            // age every point with saturation, keep those not past their lifetime
            for (int k = 0; k < trail_count; k++) begin
                aged = (trail[k].age > AgeMax - w.time_step) ? AgeMax
                                                             : trail[k].age + w.time_step;
                if (aged <= trail[k].life) begin
                    trail[kept] = trail[k];
                    trail[kept].age = aged;
                    kept++;
                end
            end
            trail_count = kept;
        end
        return CountW'(trail_count);
    endfunction

    // ------------------------------------------------------------------
    // sender: unless held steady, sends bursts of random length separated by random gaps
    // ------------------------------------------------------------------
    int unsigned burst_left = 4;
    bit          sender_steady = 1'b0;

    task automatic send_word(logic cmd, t_command_word w);
        int unsigned gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        held_expected.push_back(advance_trail(cmd, w));
        if (!sender_steady) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(30, 1);
                gap = $urandom_range(8, 1);
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end else begin
                burst_left--;
            end
        end
    endtask

    // hold off the sender until the block owes nothing
    task automatic await_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (held_expected.size() != 0);
    endtask

    task automatic send_add(logic [apq_pkg::PointW-1:0] x, logic [apq_pkg::PointW-1:0] y,
                            logic [apq_pkg::PointW-1:0] z,
                            logic [apq_pkg::PointW-1:0] life);
        send_word(apq_pkg::CMD_ADD, '{time_step: $urandom, life_span: life, pos_z: z,
                                      pos_y: y, pos_x: x});
    endtask

    task automatic send_tick(logic [apq_pkg::PointW-1:0] step);
        send_word(apq_pkg::CMD_TICK, '{time_step: step, life_span: $urandom,
                                       pos_z: $urandom, pos_y: $urandom,
                                       pos_x: $urandom});
    endtask

    // random word; lifetimes and steps are drawn around scale so that points
    // survive a handful of ticks, with the odd extreme mixed in
    task automatic send_random(int unsigned add_pct, int unsigned scale);
        longint unsigned life_hi;
        longint unsigned step_hi;
        t_command_word w;
        int unsigned pick;
        life_hi = longint'(scale) * 24;
        step_hi = longint'(scale) * 2;
        if (life_hi > AgeMax) life_hi = AgeMax;
        if (step_hi > AgeMax) step_hi = AgeMax;
        w.pos_x = $urandom;
        w.pos_y = $urandom;
        w.pos_z = $urandom;
        pick = $urandom_range(19, 0);
        w.life_span = (pick == 0) ? '0 : (pick == 1) ? AgeMax : (pick == 2) ? $urandom
                    : $urandom_range(32'(life_hi), 0);
        pick = $urandom_range(19, 0);
        w.time_step = (pick == 0) ? '0 : (pick == 1) ? AgeMax : (pick == 2) ? $urandom
                    : $urandom_range(32'(step_hi), 0);
        send_word(($urandom_range(99, 0) < add_pct) ? apq_pkg::CMD_ADD
                                                    : apq_pkg::CMD_TICK, w);
    endtask

    // ------------------------------------------------------------------
    // receiver: switches between always ready, random and throttled stalls
    // ------------------------------------------------------------------
    t_rx_mode    rx_mode = RX_OPEN;
    int unsigned rx_left = 0;

    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode <= t_rx_mode'($urandom_range(2, 0));
            rx_left <= $urandom_range(200, 20);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_OPEN: begin
                m_axis_tready <= 1'b1;
            end
            RX_RANDOM: begin
                m_axis_tready <= ($urandom_range(3, 0) != 0);
            end
            default: begin
                m_axis_tready <= (rx_left % 9) < 2;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // result check: each word against the oldest owed count
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (held_expected.size() == 0) begin
                if (error_count < MaxReported)
                    $display("%0t: result word %0d with no command pending",
                             $realtime, m_axis_tdata);
                error_count++;
            end else begin
                if (m_axis_tdata !== OutW'(held_expected[0])) begin
                    if (error_count < MaxReported)
                        $display("%0t: points_held expected %0d, got %0d",
                                 $realtime, held_expected[0], m_axis_tdata);
                    error_count++;
                end
                void'(held_expected.pop_front());
            end
        end
    end

    // watchdog: stuck handshakes end the run
    int unsigned idle_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchdogLimit) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // ticks on an empty store and on a lone point leave everything alone; then ticks age and expire two points
    task automatic test_lone_point();
        send_tick(AgeMax);
        send_add(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, '0);
        send_tick(AgeMax);
        send_add(32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000, '0);
        send_tick('0);
        send_tick(32'd1);
        send_tick(32'd1);
    endtask

    // age equal to lifetime survives, one more unit removes it, order kept
    task automatic test_expiry_edge();
        send_add(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'd5);
        send_add(32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd7);
        send_add(32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F, AgeMax);
        send_tick(32'd5);
        send_tick(32'd1);
        send_tick(32'd1);
        send_tick(32'd1);
    endtask

    // ages saturate, a maximal lifetime never runs out
    task automatic test_saturation();
        send_add($urandom, $urandom, $urandom, AgeMax);
        send_add($urandom, $urandom, $urandom, AgeMax - 1);
        send_tick(AgeMax);
        send_tick(AgeMax);
        send_tick(32'h8000_0000);
        send_tick('0);
    endtask

    // mostly adds with long lives to fill the store and push out old points,
    // then mostly ticks to drain it again
    task automatic test_full_store();
        int unsigned scale;
        for (int round = 0; round < 3; round++) begin
            scale = (round == 0) ? 1 : (round == 1) ? 32'h0001_0000
                                                    : $urandom_range(32'h0100_0000, 1);
            sender_steady = (round == 1);
            repeat (200) send_random(95, scale);
            repeat (60) send_random(10, scale);
        end
        sender_steady = 1'b0;
    endtask

    // phases of random mix and scale
    task automatic test_random_mix();
        int unsigned add_pct;
        int unsigned scale;
        repeat (16) begin
            add_pct = $urandom_range(85, 20);
            scale = (1 << $urandom_range(28, 0)) + $urandom_range(7, 0);
            sender_steady = ($urandom_range(3, 0) == 0);
            repeat (50) send_random(add_pct, scale);
        end
        sender_steady = 1'b0;
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_lone_point();
        test_expiry_edge();
        test_saturation();
        await_results();
        test_full_store();
        await_results();
        test_random_mix();

        // all words sent: wait for the rest, then a quiet spell for strays
        await_results();
        repeat (SettleCycles) @(posedge i_clk);
        if (error_count == 0 && held_expected.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
